// File: rtl/core/tx_message_buffer_queue_unit_defines.svh
// Assertion macros shared by the transmit message queue RTL.
// Define ASSERT_OFF to compile the assertions away.
`ifndef TX_MESSAGE_BUFFER_QUEUE_UNIT_DEFINES_SVH
`define TX_MESSAGE_BUFFER_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define TXMBQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define TXMBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TXMBQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TXMBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/txmbq_pkg.sv
package txmbq_pkg;

    // Pool geometry
    localparam int POOL_DEPTH    = 8;
    localparam int MESSAGE_BYTES = 64;

    localparam int IDX_W   = $clog2(POOL_DEPTH);
    localparam int POS_W   = $clog2(MESSAGE_BYTES + 1);
    localparam int USED_W  = $clog2(POOL_DEPTH + 1);
    localparam int MEM_DEPTH = POOL_DEPTH * MESSAGE_BYTES;
    localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Field widths of the stream payloads
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int BUSED_W  = 4;
    localparam int OUT_W    = 1 + BYTE_W + STATUS_W + 1 + BUSED_W;

    // Request kinds carried on the input tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_SLOT = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNC  = 2'd2;

    // Fill state of the message being written
    typedef enum logic [3:0] {
        FILL_IDLE   = 4'b0001,
        FILL_OPEN   = 4'b0010,
        FILL_REJECT = 4'b0100,
        FILL_TRUNC  = 4'b1000
    } t_fill;

    // Request sequencer of the top level
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    // Access to the message store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

    // Outcome of one request, byte excepted
    typedef struct packed {
        logic                tx_valid;
        logic [STATUS_W-1:0] status;
        logic                irq;
        logic [BUSED_W-1:0]  used;
    } t_step_res;

    // Byte address of a position inside a buffer
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] slot,
                                                    input logic [POS_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(slot) * ADDR_W'(MESSAGE_BYTES);
        return base + ADDR_W'(pos);
    endfunction

    // Ring increment of a buffer index
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(POOL_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/txmbq_store.sv
module txmbq_store (
    input  logic                        i_clk,
    input  txmbq_pkg::t_store_req       i_req,
    output logic [txmbq_pkg::BYTE_W-1:0] o_rdata
);

    logic [txmbq_pkg::BYTE_W-1:0] r_mem [0:txmbq_pkg::MEM_DEPTH-1];
    logic [txmbq_pkg::BYTE_W-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/txmbq_ctrl.sv
`include "tx_message_buffer_queue_unit_defines.svh"

module txmbq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_op,
    input  logic [txmbq_pkg::BYTE_W-1:0]  i_byte,
    input  logic                          i_last,
    output txmbq_pkg::t_store_req         o_store_req,
    output txmbq_pkg::t_step_res          o_res
);

    logic [txmbq_pkg::IDX_W-1:0]  r_head, n_head;
    logic [txmbq_pkg::IDX_W-1:0]  r_tail, n_tail;
    logic [txmbq_pkg::IDX_W-1:0]  r_open, n_open;
    logic [txmbq_pkg::USED_W-1:0] r_used, n_used;
    logic [txmbq_pkg::POS_W-1:0]  r_fp, n_fp;
    txmbq_pkg::t_fill             r_fill, n_fill;
    logic                         r_irq, n_irq;

    logic [txmbq_pkg::POS_W-1:0]  r_len [0:txmbq_pkg::POOL_DEPTH-1];
    logic [txmbq_pkg::POS_W-1:0]  r_rp  [0:txmbq_pkg::POOL_DEPTH-1];

    logic                         len_we, rp_we;
    logic [txmbq_pkg::IDX_W-1:0]  len_idx, rp_idx;
    logic [txmbq_pkg::POS_W-1:0]  len_val, rp_val;
    logic                         open_msg;
    logic [txmbq_pkg::POS_W-1:0]  head_rp, head_len;
    txmbq_pkg::t_store_req        req;
    logic                         res_valid;
    logic [txmbq_pkg::STATUS_W-1:0] res_status;

    assign open_msg = (r_fill == txmbq_pkg::FILL_OPEN) || (r_fill == txmbq_pkg::FILL_TRUNC);
    assign head_rp  = r_rp[r_head];
    assign head_len = r_len[r_head];

    // Decide the effect of one request
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_open     = r_open;
        n_used     = r_used;
        n_fp       = r_fp;
        n_fill     = r_fill;
        n_irq      = r_irq;
        len_we     = 1'b0;
        len_idx    = r_open;
        len_val    = '0;
        rp_we      = 1'b0;
        rp_idx     = r_head;
        rp_val     = '0;
        req        = '0;
        res_valid  = 1'b0;
        res_status = txmbq_pkg::STATUS_OK;

        if (i_step) begin
            if (i_op == txmbq_pkg::OP_BYTE) begin
                unique case (r_fill) inside
                    txmbq_pkg::FILL_IDLE: begin
                        if (r_used >= txmbq_pkg::USED_W'(txmbq_pkg::POOL_DEPTH)) begin
                            // pool full: reject the whole message
                            res_status = txmbq_pkg::STATUS_REJECT;
                            if (!i_last) begin
                                n_fill = txmbq_pkg::FILL_REJECT;
                            end
                        end else begin
                            // take the tail buffer and store the first byte
                            n_open    = r_tail;
                            n_tail    = txmbq_pkg::next_idx(r_tail);
                            n_used    = r_used + txmbq_pkg::USED_W'(1);
                            rp_we     = 1'b1;
                            rp_idx    = r_tail;
                            len_we    = 1'b1;
                            len_idx   = r_tail;
                            req.we    = 1'b1;
                            req.waddr = txmbq_pkg::slot_addr(r_tail, '0);
                            req.wdata = i_byte;
                            n_fp      = txmbq_pkg::POS_W'(1);
                            if (i_last) begin
                                len_val = txmbq_pkg::POS_W'(1);
                                n_irq   = 1'b1;
                                n_fill  = txmbq_pkg::FILL_IDLE;
                            end else begin
                                n_fill  = txmbq_pkg::FILL_OPEN;
                            end
                        end
                    end
                    txmbq_pkg::FILL_REJECT: begin
                        res_status = txmbq_pkg::STATUS_REJECT;
                        if (i_last) begin
                            n_fill = txmbq_pkg::FILL_IDLE;
                        end
                    end
                    txmbq_pkg::FILL_OPEN, txmbq_pkg::FILL_TRUNC: begin
                        if (r_fill == txmbq_pkg::FILL_OPEN &&
                            r_fp < txmbq_pkg::POS_W'(txmbq_pkg::MESSAGE_BYTES)) begin
                            req.we    = 1'b1;
                            req.waddr = txmbq_pkg::slot_addr(r_open, r_fp);
                            req.wdata = i_byte;
                            n_fp      = r_fp + txmbq_pkg::POS_W'(1);
                        end else begin
                            // drop bytes past the buffer end
                            n_fill     = txmbq_pkg::FILL_TRUNC;
                            res_status = txmbq_pkg::STATUS_TRUNC;
                        end
                        if (i_last) begin
                            // commit the length and arm the interrupt
                            len_we  = 1'b1;
                            len_idx = r_open;
                            len_val = n_fp;
                            n_irq   = 1'b1;
                            n_fill  = txmbq_pkg::FILL_IDLE;
                        end
                    end
                    default: begin
                        n_fill = txmbq_pkg::FILL_IDLE;
                    end
                endcase
            end else begin
                if (r_used == txmbq_pkg::USED_W'(open_msg)) begin
                    // nothing committed: disarm the interrupt
                    n_irq = 1'b0;
                end else if (head_rp >= head_len) begin
                    // head fully sent: release it
                    rp_we   = 1'b1;
                    rp_idx  = r_head;
                    len_we  = 1'b1;
                    len_idx = r_head;
                    n_head  = txmbq_pkg::next_idx(r_head);
                    n_used  = r_used - txmbq_pkg::USED_W'(1);
                end else begin
                    // fetch the next byte of the head buffer
                    req.re    = 1'b1;
                    req.raddr = txmbq_pkg::slot_addr(r_head, head_rp);
                    res_valid = 1'b1;
                    rp_we     = 1'b1;
                    rp_idx    = r_head;
                    rp_val    = head_rp + txmbq_pkg::POS_W'(1);
                end
            end
        end
    end

    // Hold pointers, counts and fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_open <= '0;
            r_used <= '0;
            r_fp   <= '0;
            r_fill <= txmbq_pkg::FILL_IDLE;
            r_irq  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_open <= n_open;
            r_used <= n_used;
            r_fp   <= n_fp;
            r_fill <= n_fill;
            r_irq  <= n_irq;
        end
    end

    // Per-buffer length and read position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < txmbq_pkg::POOL_DEPTH; i++) begin
                r_len[i] <= '0;
                r_rp[i]  <= '0;
            end
        end else begin
            if (len_we) begin
                r_len[len_idx] <= len_val;
            end
            if (rp_we) begin
                r_rp[rp_idx] <= rp_val;
            end
        end
    end

    assign o_store_req = req;
    assign o_res       = '{tx_valid: res_valid,
                           status:   res_status,
                           irq:      n_irq,
                           used:     txmbq_pkg::BUSED_W'(n_used)};

    `TXMBQ_ASSERT(a_used_bound, i_clk, i_rst_n,
        r_used <= txmbq_pkg::USED_W'(txmbq_pkg::POOL_DEPTH), "buffer count above pool depth")
    `TXMBQ_ASSERT(a_open_counted, i_clk, i_rst_n,
        !open_msg || (r_used != '0), "open message without a taken buffer")
    `TXMBQ_ASSERT(a_store_one_port, i_clk, i_rst_n,
        !(req.we && req.re), "store written and read in one request")
    `TXMBQ_ASSERT(a_tx_reads, i_clk, i_rst_n,
        !res_valid || (req.re && i_step && i_op == txmbq_pkg::OP_SLOT),
        "byte reported without a store read")

endmodule

// File: rtl/core/tx_message_buffer_queue_unit.sv
// Transmit message queue: a ring of message buffers in one byte memory.
// Slave stream: one request per beat. tuser selects the kind: 0 queues
// tdata[7:0] as a message byte (tlast marks the final byte, which commits
// the message and arms the transmit interrupt), 1 is a transmitter slot
// that either disarms the interrupt, frees a fully sent head buffer or
// fetches the next byte of the head buffer.
// Master stream: one result per request, tdata carries tx_valid, tx_byte,
// status, irq_enabled and buffers_used.
// A result without a byte is registered and offered in the cycle after
// the request; a byte fetch passes through ST_READ first, since the byte
// memory has a registered read port. One request is in flight at a time:
// a new request waits until the master side accepts the last result.
// Reset empties the pool, closes any open message and disarms the
// interrupt; buffer contents are not cleared, and no pass is needed.
// While the receiver holds tready low the result register holds and
// o_s_axis_tready stays low.
`include "tx_message_buffer_queue_unit_defines.svh"

module tx_message_buffer_queue_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [txmbq_pkg::BYTE_W-1:0]  i_s_axis_tdata,  // [7:0] message_byte
    input  logic                          i_s_axis_tlast,  // last_byte
    input  logic                          i_s_axis_tuser,  // [0] op
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [10:9] status, [11] irq_enabled,
    // [15:12] buffers_used
    output logic [txmbq_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    txmbq_pkg::t_state            r_state, n_state;
    txmbq_pkg::t_step_res         r_res;
    logic [txmbq_pkg::BYTE_W-1:0] r_tx_byte;
    txmbq_pkg::t_store_req        store_req;
    txmbq_pkg::t_step_res         step_res;
    logic [txmbq_pkg::BYTE_W-1:0] store_rdata;
    logic                         s_accept;

    assign o_s_axis_tready = (r_state == txmbq_pkg::ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    txmbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_accept),
        .i_op        (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_store_req (store_req),
        .o_res       (step_res)
    );

    txmbq_store u_store (
        .i_clk   (i_clk),
        .i_req   (store_req),
        .o_rdata (store_rdata)
    );

    // Sequence one request through fetch and delivery
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            txmbq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = step_res.tx_valid ? txmbq_pkg::ST_READ : txmbq_pkg::ST_OUT;
                end
            end
            txmbq_pkg::ST_READ: begin
                n_state = txmbq_pkg::ST_OUT;
            end
            txmbq_pkg::ST_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = txmbq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = txmbq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= txmbq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the result and, after a fetch, the byte
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_res     <= step_res;
            r_tx_byte <= '0;
        end else if (r_state == txmbq_pkg::ST_READ) begin
            r_tx_byte <= store_rdata;
        end
    end

    assign o_m_axis_tvalid = (r_state == txmbq_pkg::ST_OUT);
    assign o_m_axis_tdata  = {r_res.used, r_res.irq, r_res.status, r_tx_byte, r_res.tx_valid};

    `TXMBQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n,
        s_accept, !o_s_axis_tready, "request taken while one is in flight")
    `TXMBQ_ASSERT_NEXT(a_fetch_done, i_clk, i_rst_n,
        r_state == txmbq_pkg::ST_READ, o_m_axis_tvalid && r_res.tx_valid,
        "fetched byte not delivered")
    `TXMBQ_ASSERT(a_fetch_issued, i_clk, i_rst_n,
        !(s_accept && step_res.tx_valid) || store_req.re, "fetch without a store read")

endmodule
